@@ hdl/two_lane_lap_timer_macros.svh @@
// two_lane_lap_timer_macros.svh: assertion macros for the lap timer
// used by the top level; expects clk_i and rst_ni in the including module
`ifndef TWO_LANE_LAP_TIMER_MACROS_SVH
`define TWO_LANE_LAP_TIMER_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define TLLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define TLLT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TLLT_ASSERT(lbl, prop, msg)
`define TLLT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ hdl/ltmr_pkg.sv @@
// ltmr_pkg: shared types and constants of the two-lane lap timer
// no dependencies; used by ltmr_div, ltmr_dp, ltmr_ctrl and the top level
`default_nettype none

package ltmr_pkg;

  // field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // register reset values
  localparam logic [TIME_W-1:0]  MIN_LAP_RST  = 32'd1000;
  localparam logic [TIME_W-1:0]  DEBOUNCE_RST = 32'd1000;
  localparam logic [COUNT_W-1:0] TARGET_RST   = 16'd0;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TRIGGER = 2'd0,
    CMD_TOGGLE  = 2'd1,
    CMD_OFFSET  = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LAP  = 2'd0,
    CFG_DEBOUNCE = 2'd1,
    CFG_TARGET   = 2'd2
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic check;
    logic apply;
    logic div_start;
    logic mean_load;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lap_rec;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/ltmr_div.sv @@
// ltmr_div: radix-2 restoring divider, one quotient bit per cycle
// depends on ltmr_pkg for the operand widths
`default_nettype none

module ltmr_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ltmr_pkg::TIME_W-1:0]  dividend_i,
  input  wire logic [ltmr_pkg::COUNT_W-1:0] divisor_i,
  output logic                              done_o,
  output logic [ltmr_pkg::TIME_W-1:0]       quotient_o
);

  localparam int unsigned CNT_W = $clog2(ltmr_pkg::TIME_W);

  logic [ltmr_pkg::TIME_W-1:0]  quo_q, quo_d;
  logic [ltmr_pkg::COUNT_W-1:0] rem_q, rem_d;
  logic [ltmr_pkg::COUNT_W-1:0] dsr_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         busy_q, done_q;
  logic [ltmr_pkg::COUNT_W:0]   shifted;
  logic                         fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, quo_q[ltmr_pkg::TIME_W-1]};
    fits    = shifted >= {1'b0, dsr_q};
    rem_d   = fits ? ltmr_pkg::COUNT_W'(shifted - {1'b0, dsr_q})
                   : ltmr_pkg::COUNT_W'(shifted);
    quo_d   = {quo_q[ltmr_pkg::TIME_W-2:0], fits};
  end

  // control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ltmr_pkg::TIME_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ hdl/ltmr_dp.sv @@
// ltmr_dp: lap timer datapath with lane state, history, config and result registers
// depends on ltmr_pkg and instantiates ltmr_div
`default_nettype none

module ltmr_dp #(
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned LANE_COUNT    = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ltmr_pkg::ctrl_cmd_t            ctrl_i,
  output ltmr_pkg::dp_status_t                status_o,
  input  wire logic [ltmr_pkg::CMD_W-1:0]     in_cmd_i,
  input  wire logic                           in_lane_i,
  input  wire logic [ltmr_pkg::TIME_W-1:0]    in_time_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [ltmr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ltmr_pkg::TIME_W-1:0]    cfg_data_i,
  output logic                                lane_out_o,
  output logic [ltmr_pkg::TIME_W-1:0]         newest_lap_o,
  output logic                                lap_recorded_o,
  output logic                                send_lap_o,
  output logic [ltmr_pkg::COUNT_W-1:0]        lap_total_o,
  output logic [ltmr_pkg::TIME_W-1:0]         fastest_lap_o,
  output logic [ltmr_pkg::TIME_W-1:0]         average_lap_o,
  output logic                                paused_out_o
);

  localparam int unsigned TW = ltmr_pkg::TIME_W;
  localparam int unsigned CW = ltmr_pkg::COUNT_W;

  // configuration registers
  logic [TW-1:0] min_lap_q, debounce_q;
  logic [CW-1:0] target_q;

  // captured request
  ltmr_pkg::cmd_e cmd_q;
  logic           lane_q;
  logic [TW-1:0]  time_q;

  // lane state
  logic          paused_q;
  logic [TW-1:0] prev_q  [LANE_COUNT];
  logic [TW-1:0] trig_q  [LANE_COUNT];
  logic [TW-1:0] total_q [LANE_COUNT];
  logic [CW-1:0] count_q [LANE_COUNT];
  logic [TW-1:0] best_q  [LANE_COUNT];
  logic [TW-1:0] mean_q  [LANE_COUNT];
  logic          armed_q [LANE_COUNT];
  logic [TW-1:0] hist_q  [LANE_COUNT][HISTORY_DEPTH];

  // per-request working registers
  logic          pass_q;
  logic [TW-1:0] lap_q;
  logic          rec_q;

  // result registers
  logic          lane_out_q, rec_out_q, send_q, paused_out_q;
  logic [TW-1:0] newest_q, fastest_q, average_q;
  logic [CW-1:0] total_out_q;

  // selected lane view
  logic          lane_ok;
  logic [TW-1:0] sel_prev, sel_trig, sel_total, sel_best, sel_hist0, sel_mean;
  logic [CW-1:0] sel_count, cnt_inc;
  logic          sel_armed;
  logic          rec_c;
  logic [TW-1:0] total_new;
  logic          div_done;
  logic [TW-1:0] quotient;

  // lane mux
  always_comb begin
    lane_ok   = int'(lane_q) < LANE_COUNT;
    sel_prev  = '0;
    sel_trig  = '0;
    sel_total = '0;
    sel_best  = '0;
    sel_hist0 = '0;
    sel_mean  = '0;
    sel_count = '0;
    sel_armed = 1'b0;
    for (int l = 0; l < LANE_COUNT; l++) begin
      if (int'(lane_q) == l) begin
        sel_prev  = prev_q[l];
        sel_trig  = trig_q[l];
        sel_total = total_q[l];
        sel_best  = best_q[l];
        sel_hist0 = hist_q[l][0];
        sel_mean  = mean_q[l];
        sel_count = count_q[l];
        sel_armed = armed_q[l];
      end
    end
  end

  // lap decision for the apply step
  always_comb begin
    rec_c     = (cmd_q == ltmr_pkg::CMD_TRIGGER) && lane_ok && pass_q && sel_armed &&
                (lap_q >= min_lap_q);
    cnt_inc   = (sel_count == '1) ? sel_count : sel_count + 1'b1;
    total_new = sel_total + lap_q;
  end

  assign status_o.lap_rec  = rec_c;
  assign status_o.div_done = div_done;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lap_q  <= ltmr_pkg::MIN_LAP_RST;
      debounce_q <= ltmr_pkg::DEBOUNCE_RST;
      target_q   <= ltmr_pkg::TARGET_RST;
    end else if (cfg_we_i) begin
      unique case (ltmr_pkg::cfg_idx_e'(cfg_index_i))
        ltmr_pkg::CFG_MIN_LAP:  min_lap_q  <= cfg_data_i;
        ltmr_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        ltmr_pkg::CFG_TARGET:   target_q   <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // request capture and debounce / lap time check
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= ltmr_pkg::cmd_e'(in_cmd_i);
      lane_q <= in_lane_i;
      time_q <= in_time_i;
    end
    if (ctrl_i.check) begin
      pass_q <= !paused_q && ((time_q - sel_trig) >= debounce_q);
      lap_q  <= time_q - sel_prev;
    end
    if (ctrl_i.apply) begin
      rec_q <= rec_c;
    end
  end

  // lane state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q <= 1'b1;
      for (int l = 0; l < LANE_COUNT; l++) begin
        prev_q[l]  <= '0;
        trig_q[l]  <= '0;
        total_q[l] <= '0;
        count_q[l] <= '0;
        best_q[l]  <= '0;
        mean_q[l]  <= '0;
        armed_q[l] <= 1'b0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          hist_q[l][k] <= '0;
        end
      end
    end else begin
      if (ctrl_i.apply) begin
        // pause flag: toggle, or stop at the target lap count
        if (cmd_q == ltmr_pkg::CMD_TOGGLE) begin
          paused_q <= !paused_q;
        end else if (rec_c && (target_q != '0) && (cnt_inc == target_q)) begin
          paused_q <= 1'b1;
        end
        for (int l = 0; l < LANE_COUNT; l++) begin
          if (lane_ok && (int'(lane_q) == l)) begin
            unique case (cmd_q)
              ltmr_pkg::CMD_TRIGGER: begin
                if (pass_q) begin
                  trig_q[l] <= time_q;
                  if (!armed_q[l]) begin
                    // first trigger only arms the lane
                    armed_q[l] <= 1'b1;
                    prev_q[l]  <= time_q;
                  end else if (rec_c) begin
                    prev_q[l]  <= time_q;
                    for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
                      hist_q[l][k] <= hist_q[l][k-1];
                    end
                    hist_q[l][0] <= lap_q;
                    total_q[l]   <= total_new;
                    count_q[l]   <= cnt_inc;
                    if ((best_q[l] == '0) || (best_q[l] > lap_q)) begin
                      best_q[l] <= lap_q;
                    end
                  end
                end
              end
              ltmr_pkg::CMD_OFFSET: begin
                prev_q[l]  <= time_q;
                armed_q[l] <= 1'b1;
              end
              ltmr_pkg::CMD_CLEAR: begin
                prev_q[l]  <= '0;
                total_q[l] <= '0;
                count_q[l] <= '0;
                best_q[l]  <= '0;
                mean_q[l]  <= '0;
                armed_q[l] <= 1'b0;
                for (int k = 0; k < HISTORY_DEPTH; k++) begin
                  hist_q[l][k] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      // average from the divider
      if (ctrl_i.mean_load) begin
        for (int l = 0; l < LANE_COUNT; l++) begin
          if (int'(lane_q) == l) begin
            mean_q[l] <= quotient;
          end
        end
      end
    end
  end

  // average = total / count, count is nonzero after a recorded lap
  ltmr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (sel_total),
    .divisor_i  (sel_count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      lane_out_q   <= lane_q;
      newest_q     <= lane_ok ? sel_hist0 : '0;
      rec_out_q    <= rec_q;
      send_q       <= (cmd_q == ltmr_pkg::CMD_TRIGGER) && lane_ok && pass_q &&
                      (sel_hist0 != '0);
      total_out_q  <= lane_ok ? sel_count : '0;
      fastest_q    <= lane_ok ? sel_best : '0;
      average_q    <= lane_ok ? sel_mean : '0;
      paused_out_q <= paused_q;
    end
  end

  assign lane_out_o     = lane_out_q;
  assign newest_lap_o   = newest_q;
  assign lap_recorded_o = rec_out_q;
  assign send_lap_o     = send_q;
  assign lap_total_o    = total_out_q;
  assign fastest_lap_o  = fastest_q;
  assign average_lap_o  = average_q;
  assign paused_out_o   = paused_out_q;

endmodule

`default_nettype wire

@@ hdl/ltmr_ctrl.sv @@
// ltmr_ctrl: sequencer of the lap timer and owner of the request and result handshakes
// depends on ltmr_pkg for the command and status structs
`default_nettype none

module ltmr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire ltmr_pkg::dp_status_t status_i,
  output ltmr_pkg::ctrl_cmd_t       ctrl_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_APPLY  = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DWAIT  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ctrl_o.check = 1'b1;
        state_d      = ST_APPLY;
      end
      ST_APPLY: begin
        ctrl_o.apply = 1'b1;
        state_d      = status_i.lap_rec ? ST_DSTART : ST_FINISH;
      end
      ST_DSTART: begin
        ctrl_o.div_start = 1'b1;
        state_d          = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (status_i.div_done) begin
          ctrl_o.mean_load = 1'b1;
          state_d          = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ctrl_o.load_out = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/two_lane_lap_timer.sv @@
// two_lane_lap_timer: top level of the two-lane lap timer
// depends on ltmr_pkg, ltmr_ctrl, ltmr_dp, ltmr_div and the assertion macro header
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    cmd_i, lane_i, time_ms_i
//   out      output     out_valid_o / out_stall_i  lane_out_o .. paused_out_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one request at a time: a command that records no lap runs the check, apply and
// finish steps; a recorded lap also runs the 32-step radix-2 divider
// that updates the lane average
// the next request is taken while a result still waits in the output register
// reset clears all lane state and history at once, no clearing pass
// a stalled result holds the sequencer in its final step until it is taken
`default_nettype none
`include "two_lane_lap_timer_macros.svh"

module two_lane_lap_timer #(
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned LANE_COUNT    = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request input
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ltmr_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic                           lane_i,
  input  wire logic [ltmr_pkg::TIME_W-1:0]    time_ms_i,
  // result output
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                lane_out_o,
  output logic [ltmr_pkg::TIME_W-1:0]         newest_lap_o,
  output logic                                lap_recorded_o,
  output logic                                send_lap_o,
  output logic [ltmr_pkg::COUNT_W-1:0]        lap_total_o,
  output logic [ltmr_pkg::TIME_W-1:0]         fastest_lap_o,
  output logic [ltmr_pkg::TIME_W-1:0]         average_lap_o,
  output logic                                paused_out_o,
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ltmr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ltmr_pkg::TIME_W-1:0]    cfg_data_i
);

  ltmr_pkg::ctrl_cmd_t  ctrl;
  ltmr_pkg::dp_status_t status;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  ltmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  ltmr_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LANE_COUNT    (LANE_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .in_cmd_i       (cmd_i),
    .in_lane_i      (lane_i),
    .in_time_i      (time_ms_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .lane_out_o     (lane_out_o),
    .newest_lap_o   (newest_lap_o),
    .lap_recorded_o (lap_recorded_o),
    .send_lap_o     (send_lap_o),
    .lap_total_o    (lap_total_o),
    .fastest_lap_o  (fastest_lap_o),
    .average_lap_o  (average_lap_o),
    .paused_out_o   (paused_out_o)
  );

  // assertions
  `TLLT_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "no stall")
  `TLLT_ASSERT_NEVER(a_send_zero_lap, out_valid_o && send_lap_o && ~|newest_lap_o, "zero lap sent")
  `TLLT_ASSERT_NEVER(a_rec_no_count, out_valid_o && lap_recorded_o && ~|lap_total_o, "zero count")

endmodule

`default_nettype wire
